>>> hdl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg: shared types and constants for the circular brush stamp unit
// Field widths, register indexes, opcodes and reset values used by the
// channel interfaces and the stamp unit.
// ----------------------------------------------------------------------------
package cbs_pkg;

  // Default sizes of the pixel store and the brush.
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_MAX_RADIUS = 32;

  // Configuration port.
  localparam int REG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_BOARD_WIDTH  = 3'd0,
    REG_BOARD_HEIGHT = 3'd1,
    REG_BRUSH_RADIUS = 3'd2,
    REG_INK_RED      = 3'd3,
    REG_INK_GREEN    = 3'd4,
    REG_INK_BLUE     = 3'd5
  } reg_index_t;

  // Register widths and reset values.
  localparam int BOARD_W  = 10;
  localparam int RADIUS_W = 6;
  localparam int CHAN_W   = 8;

  localparam logic [BOARD_W-1:0]  RST_BOARD_WIDTH  = 10'd512;
  localparam logic [BOARD_W-1:0]  RST_BOARD_HEIGHT = 10'd512;
  localparam logic [RADIUS_W-1:0] RST_BRUSH_RADIUS = 6'd8;
  localparam logic [CHAN_W-1:0]   RST_INK          = 8'd255;

  // Item opcodes.
  localparam logic OP_STAMP = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Item and result field widths.
  localparam int CENTRE_W   = 12;
  localparam int READ_POS_W = 9;
  localparam int REGION_POS_W  = 9;
  localparam int REGION_SIZE_W = 7;

  // Signed width for box arithmetic: centre +/- radius against board size.
  localparam int COORD_W = 14;

  // Alpha of a pixel inside the brush.
  localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;

  // Stored pixel: alpha in the top byte, then blue, green and red.
  localparam int PIXEL_W = 4 * CHAN_W;

endpackage

>>> hdl/cbs_channels.sv
// ----------------------------------------------------------------------------
// cbs_channels: valid/ready channels of the circular brush stamp unit
// The item channel carries stamp and read requests; the result channel
// carries the dirty rectangle or the pixel read back.
// ----------------------------------------------------------------------------
interface cbs_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [cbs_pkg::CENTRE_W-1:0]  centre_col;
  logic signed [cbs_pkg::CENTRE_W-1:0]  centre_row;
  logic [cbs_pkg::READ_POS_W-1:0]       read_col;
  logic [cbs_pkg::READ_POS_W-1:0]       read_row;

  modport source (
    output valid, opcode, centre_col, centre_row, read_col, read_row,
    input  ready
  );
  modport sink (
    input  valid, opcode, centre_col, centre_row, read_col, read_row,
    output ready
  );
endinterface

interface cbs_result_if;
  logic                               valid;
  logic                               ready;
  logic [cbs_pkg::REGION_POS_W-1:0]   region_left;
  logic [cbs_pkg::REGION_POS_W-1:0]   region_top;
  logic [cbs_pkg::REGION_SIZE_W-1:0]  region_cols;
  logic [cbs_pkg::REGION_SIZE_W-1:0]  region_rows;
  logic [cbs_pkg::CHAN_W-1:0]         pixel_red;
  logic [cbs_pkg::CHAN_W-1:0]         pixel_green;
  logic [cbs_pkg::CHAN_W-1:0]         pixel_blue;
  logic [cbs_pkg::CHAN_W-1:0]         pixel_alpha;

  modport source (
    output valid, region_left, region_top, region_cols, region_rows,
           pixel_red, pixel_green, pixel_blue, pixel_alpha,
    input  ready
  );
  modport sink (
    input  valid, region_left, region_top, region_cols, region_rows,
           pixel_red, pixel_green, pixel_blue, pixel_alpha,
    output ready
  );
endinterface

>>> hdl/cbs_ram.sv
// ----------------------------------------------------------------------------
// cbs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read in the same clock.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/circular_brush_stamp_unit.sv
// Stamp: a read-modify-write on the pixel store for each pixel of the box, plus a
// row offset square for each row; an empty stamp goes straight from setup to the
// result. Read: issue, wait, then the result register.
// One item at a time; the next is taken while the result waits for its beat.
// Reset starts a clearing pass over all MAX_WIDTH * MAX_HEIGHT pixels (262144 by
// default), one pixel a cycle, before the first item is taken.
// ----------------------------------------------------------------------------
// circular_brush_stamp_unit: circular brush stamp with max alpha
// Stamps a filled circle into an RGBA pixel store, keeping the larger alpha,
// and reads single pixels back. A shared squarer serves radius, row and
// column offsets under a small sequencer.
// ----------------------------------------------------------------------------
module circular_brush_stamp_unit #(
  parameter int MAX_WIDTH  = cbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbs_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = cbs_pkg::DEF_MAX_RADIUS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_en,
  input  logic [cbs_pkg::REG_INDEX_W-1:0]   reg_index,
  input  logic [cbs_pkg::CFG_DATA_W-1:0]    write_data,
  cbs_item_if.sink                          item,
  cbs_result_if.source                      result
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_RADIUS) + 2;
  localparam int PW    = 2 * DW;
  localparam int CW    = cbs_pkg::COORD_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_ROW,
    S_PIX_RD,
    S_PIX_WR,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [cbs_pkg::BOARD_W-1:0]  board_width;
  logic [cbs_pkg::BOARD_W-1:0]  board_height;
  logic [cbs_pkg::RADIUS_W-1:0] brush_radius;
  logic [cbs_pkg::CHAN_W-1:0]   ink_red;
  logic [cbs_pkg::CHAN_W-1:0]   ink_green;
  logic [cbs_pkg::CHAN_W-1:0]   ink_blue;

  // Captured item.
  logic                                opcode;
  logic signed [cbs_pkg::CENTRE_W-1:0] centre_col;
  logic signed [cbs_pkg::CENTRE_W-1:0] centre_row;
  logic [cbs_pkg::READ_POS_W-1:0]      read_col;
  logic [cbs_pkg::READ_POS_W-1:0]      read_row;

  // Sweep state.
  logic [AW-1:0]    clr_addr;
  logic [COL_W-1:0] left_col;
  logic [COL_W:0]   col_end;
  logic [ROW_W:0]   row_end;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [PW-1:0]    rad_sq;
  logic [PW-1:0]    dy_sq;
  logic [PW-1:0]    dx_sq;
  logic             read_inside;

  // Pending result fields.
  logic [cbs_pkg::REGION_POS_W-1:0]  reg_left;
  logic [cbs_pkg::REGION_POS_W-1:0]  reg_top;
  logic [cbs_pkg::REGION_SIZE_W-1:0] reg_cols;
  logic [cbs_pkg::REGION_SIZE_W-1:0] reg_rows;
  logic [cbs_pkg::PIXEL_W-1:0]       read_pixel;

  // Result register.
  logic                               res_valid;
  logic [cbs_pkg::REGION_POS_W-1:0]   res_left;
  logic [cbs_pkg::REGION_POS_W-1:0]   res_top;
  logic [cbs_pkg::REGION_SIZE_W-1:0]  res_cols;
  logic [cbs_pkg::REGION_SIZE_W-1:0]  res_rows;
  logic [cbs_pkg::PIXEL_W-1:0]        res_pixel;

  // Pixel store port.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [cbs_pkg::PIXEL_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [cbs_pkg::PIXEL_W-1:0] ram_rdata;

  // Effective board size and radius, clamped to the store and brush limits.
  logic signed [CW-1:0] bw_c;
  logic signed [CW-1:0] bh_c;
  logic signed [CW-1:0] rad_c;

  assign bw_c  = (int'(board_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(board_width);
  assign bh_c  = (int'(board_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(board_height);
  assign rad_c = (int'(brush_radius) > MAX_RADIUS) ? CW'(MAX_RADIUS) : CW'(brush_radius);

  // Brush box clipped to the board, width rounded down to even.
  logic signed [CW-1:0] xs, ys;
  logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [CW-1:0] left_s, top_s, right_s, bottom_s;
  logic signed [CW-1:0] w_s, w_even, h_s;
  logic                 box_empty;

  assign xs       = CW'(centre_col);
  assign ys       = CW'(centre_row);
  assign lo_x     = xs - rad_c;
  assign lo_y     = ys - rad_c;
  assign hi_x     = xs + rad_c;
  assign hi_y     = ys + rad_c;
  assign left_s   = (lo_x > 0) ? lo_x : '0;
  assign top_s    = (lo_y > 0) ? lo_y : '0;
  assign right_s  = (hi_x < bw_c) ? hi_x : bw_c;
  assign bottom_s = (hi_y < bh_c) ? hi_y : bh_c;
  assign w_s      = right_s - left_s;
  assign h_s      = bottom_s - top_s;
  assign w_even   = {w_s[CW-1:1], 1'b0};
  assign box_empty = (w_even <= 0) || (h_s <= 0);

  // Offsets from the centre of the pixel being visited.
  logic signed [CW-1:0] dx, dy;

  assign dx = CW'(col) - xs;
  assign dy = CW'(row) - ys;

  // Shared squarer: radius at setup, row offset per row, column offset per pixel.
  logic signed [DW-1:0] sq_in;
  logic signed [PW-1:0] sq_out;

  always_comb begin
    case (state)
      S_SETUP:  sq_in = DW'(rad_c);
      S_ROW:    sq_in = DW'(dy);
      S_PIX_RD: sq_in = DW'(dx);
      default:  sq_in = '0;
    endcase
  end

  assign sq_out = sq_in * sq_in;

  // Mask test and alpha update for the pixel whose old value has arrived.
  logic [PW:0]                dist_sq;
  logic                       in_brush;
  logic [cbs_pkg::CHAN_W-1:0] alpha_new;

  assign dist_sq   = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign in_brush  = dist_sq < {1'b0, rad_sq};
  assign alpha_new = in_brush ? cbs_pkg::ALPHA_FULL
                              : ram_rdata[cbs_pkg::PIXEL_W-1 -: cbs_pkg::CHAN_W];

  // Store addresses: row-major with a fixed pitch.
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_in_board;

  assign pix_addr    = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  assign rd_addr     = AW'(read_row) * AW'(MAX_WIDTH) + AW'(read_col);
  assign rd_in_board = (CW'(read_col) < bw_c) && (CW'(read_row) < bh_c);

  // Last pixel of a row and last row of the box.
  logic col_last, row_last;

  assign col_last = ({1'b0, col} + (COL_W + 1)'(1)) == col_end;
  assign row_last = ({1'b0, row} + (ROW_W + 1)'(1)) == row_end;

  // Pixel store port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pix_addr;
    ram_wdata = {alpha_new, ink_blue, ink_green, ink_red};
    ram_raddr = pix_addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_PIX_WR: begin
        ram_we = (alpha_new != '0);
      end
      S_RD_ISSUE: begin
        ram_raddr = rd_addr;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cbs_ram #(
    .WIDTH (cbs_pkg::PIXEL_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration writes, taken in any state.
  always_ff @(posedge clk) begin
    if (rst) begin
      board_width  <= cbs_pkg::RST_BOARD_WIDTH;
      board_height <= cbs_pkg::RST_BOARD_HEIGHT;
      brush_radius <= cbs_pkg::RST_BRUSH_RADIUS;
      ink_red      <= cbs_pkg::RST_INK;
      ink_green    <= cbs_pkg::RST_INK;
      ink_blue     <= cbs_pkg::RST_INK;
    end else if (write_en) begin
      case (reg_index)
        cbs_pkg::REG_BOARD_WIDTH:  board_width  <= write_data[cbs_pkg::BOARD_W-1:0];
        cbs_pkg::REG_BOARD_HEIGHT: board_height <= write_data[cbs_pkg::BOARD_W-1:0];
        cbs_pkg::REG_BRUSH_RADIUS: brush_radius <= write_data[cbs_pkg::RADIUS_W-1:0];
        cbs_pkg::REG_INK_RED:      ink_red      <= write_data[cbs_pkg::CHAN_W-1:0];
        cbs_pkg::REG_INK_GREEN:    ink_green    <= write_data[cbs_pkg::CHAN_W-1:0];
        cbs_pkg::REG_INK_BLUE:     ink_blue     <= write_data[cbs_pkg::CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A finished item loads the result register once the previous beat has gone.
  logic res_load;

  assign res_load = (state == S_FINISH) && (!res_valid || result.ready);

  // Sequencer with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      // The result register empties on its beat unless a new result refills it.
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item.valid) begin
            opcode     <= item.opcode;
            centre_col <= item.centre_col;
            centre_row <= item.centre_row;
            read_col   <= item.read_col;
            read_row   <= item.read_row;
            state      <= (item.opcode == cbs_pkg::OP_READ) ? S_RD_ISSUE : S_SETUP;
          end
        end

        S_SETUP: begin
          rad_sq   <= sq_out[PW-1:0];
          left_col <= COL_W'(left_s);
          col      <= COL_W'(left_s);
          row      <= ROW_W'(top_s);
          col_end  <= (COL_W + 1)'(left_s + w_even);
          row_end  <= (ROW_W + 1)'(bottom_s);
          if (box_empty) begin
            reg_left <= '0;
            reg_top  <= '0;
            reg_cols <= '0;
            reg_rows <= '0;
            state    <= S_FINISH;
          end else begin
            reg_left <= cbs_pkg::REGION_POS_W'(left_s);
            reg_top  <= cbs_pkg::REGION_POS_W'(top_s);
            reg_cols <= cbs_pkg::REGION_SIZE_W'(w_even);
            reg_rows <= cbs_pkg::REGION_SIZE_W'(h_s);
            state    <= S_ROW;
          end
        end

        S_ROW: begin
          dy_sq <= sq_out[PW-1:0];
          col   <= left_col;
          state <= S_PIX_RD;
        end

        S_PIX_RD: begin
          dx_sq <= sq_out[PW-1:0];
          state <= S_PIX_WR;
        end

        S_PIX_WR: begin
          if (col_last) begin
            if (row_last) begin
              state <= S_FINISH;
            end else begin
              row   <= row + ROW_W'(1);
              state <= S_ROW;
            end
          end else begin
            col   <= col + COL_W'(1);
            state <= S_PIX_RD;
          end
        end

        S_RD_ISSUE: begin
          read_inside <= rd_in_board;
          state       <= S_RD_WAIT;
        end

        S_RD_WAIT: begin
          read_pixel <= read_inside ? ram_rdata : '0;
          state      <= S_FINISH;
        end

        S_FINISH: begin
          // Load the result once the previous one has gone.
          if (res_load) begin
            if (opcode == cbs_pkg::OP_READ) begin
              res_left  <= '0;
              res_top   <= '0;
              res_cols  <= '0;
              res_rows  <= '0;
              res_pixel <= read_pixel;
            end else begin
              res_left  <= reg_left;
              res_top   <= reg_top;
              res_cols  <= reg_cols;
              res_rows  <= reg_rows;
              res_pixel <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Channel outputs.
  assign item.ready         = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.region_left = res_left;
  assign result.region_top  = res_top;
  assign result.region_cols = res_cols;
  assign result.region_rows = res_rows;
  assign result.pixel_red   = res_pixel[0 +: cbs_pkg::CHAN_W];
  assign result.pixel_green = res_pixel[cbs_pkg::CHAN_W +: cbs_pkg::CHAN_W];
  assign result.pixel_blue  = res_pixel[2 * cbs_pkg::CHAN_W +: cbs_pkg::CHAN_W];
  assign result.pixel_alpha = res_pixel[3 * cbs_pkg::CHAN_W +: cbs_pkg::CHAN_W];

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the circular brush stamp unit
// Sends stamp and read beats over the item channel and keeps its own model
// of the pixel store, the board size, the brush and the ink. Every result
// beat is checked field by field against the oldest predicted result.
// Directed cases cover clipping, odd widths, empty stamps, oversized and
// zero registers, resizing and reads outside the board. Random phases then
// follow, each with its own register settings. Both sides idle at random.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                             opcode;
  logic [cbs_pkg::CENTRE_W-1:0]     centre_col;
  logic [cbs_pkg::CENTRE_W-1:0]     centre_row;
  logic [cbs_pkg::READ_POS_W-1:0]   read_col;
  logic [cbs_pkg::READ_POS_W-1:0]   read_row;
} brush_req_t;

typedef struct packed {
  logic [cbs_pkg::REGION_POS_W-1:0]  region_left;
  logic [cbs_pkg::REGION_POS_W-1:0]  region_top;
  logic [cbs_pkg::REGION_SIZE_W-1:0] region_cols;
  logic [cbs_pkg::REGION_SIZE_W-1:0] region_rows;
  logic [cbs_pkg::CHAN_W-1:0]        pixel_red;
  logic [cbs_pkg::CHAN_W-1:0]        pixel_green;
  logic [cbs_pkg::CHAN_W-1:0]        pixel_blue;
  logic [cbs_pkg::CHAN_W-1:0]        pixel_alpha;
} brush_reply_t;

// Model of the pixel store and registers, with the queue of results still due.
class canvas_model;
  localparam int CANVAS_W  = cbs_pkg::DEF_MAX_WIDTH;
  localparam int CANVAS_H  = cbs_pkg::DEF_MAX_HEIGHT;
  localparam int CANVAS_R  = cbs_pkg::DEF_MAX_RADIUS;
  localparam int SHOWN_MAX = 60;

  bit [cbs_pkg::PIXEL_W-1:0]  canvas [0:CANVAS_W*CANVAS_H-1];
  bit [cbs_pkg::BOARD_W-1:0]  width_reg  = cbs_pkg::RST_BOARD_WIDTH;
  bit [cbs_pkg::BOARD_W-1:0]  height_reg = cbs_pkg::RST_BOARD_HEIGHT;
  bit [cbs_pkg::RADIUS_W-1:0] radius_reg = cbs_pkg::RST_BRUSH_RADIUS;
  bit [cbs_pkg::CHAN_W-1:0]   red_reg    = cbs_pkg::RST_INK;
  bit [cbs_pkg::CHAN_W-1:0]   green_reg  = cbs_pkg::RST_INK;
  bit [cbs_pkg::CHAN_W-1:0]   blue_reg   = cbs_pkg::RST_INK;
  brush_reply_t               pending_replies [$];
  int                         mismatch_count;

  function void set_register(logic [cbs_pkg::REG_INDEX_W-1:0] idx,
                             logic [cbs_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      cbs_pkg::REG_BOARD_WIDTH:  width_reg  = data[cbs_pkg::BOARD_W-1:0];
      cbs_pkg::REG_BOARD_HEIGHT: height_reg = data[cbs_pkg::BOARD_W-1:0];
      cbs_pkg::REG_BRUSH_RADIUS: radius_reg = data[cbs_pkg::RADIUS_W-1:0];
      cbs_pkg::REG_INK_RED:      red_reg    = data[cbs_pkg::CHAN_W-1:0];
      cbs_pkg::REG_INK_GREEN:    green_reg  = data[cbs_pkg::CHAN_W-1:0];
      cbs_pkg::REG_INK_BLUE:     blue_reg   = data[cbs_pkg::CHAN_W-1:0];
      default: ;
    endcase
  endfunction

  // Register values above the store or brush limits act as the limit.
  function int eff_width();
    return (int'(width_reg) > CANVAS_W) ? CANVAS_W : int'(width_reg);
  endfunction

  function int eff_height();
    return (int'(height_reg) > CANVAS_H) ? CANVAS_H : int'(height_reg);
  endfunction

  function int eff_radius();
    return (int'(radius_reg) > CANVAS_R) ? CANVAS_R : int'(radius_reg);
  endfunction

  function int pending();
    return pending_replies.size();
  endfunction

  // Applies one accepted item to the store and queues the result it gives.
  function void accept_request(brush_req_t req);
    int bw, bh, rad, x, y, left, top, right, bottom, w, h, rr;
    int row, col, dx, dy, idx;
    bit [cbs_pkg::PIXEL_W-1:0] pix;
    bit [cbs_pkg::CHAN_W-1:0]  mask, alpha;
    brush_reply_t              want;
    bw = eff_width();
    bh = eff_height();
    want = '0;
    if (req.opcode == cbs_pkg::OP_READ) begin
      if (int'(req.read_col) < bw && int'(req.read_row) < bh) begin
        pix = canvas[int'(req.read_row) * CANVAS_W + int'(req.read_col)];
        {want.pixel_alpha, want.pixel_blue, want.pixel_green, want.pixel_red} = pix;
      end
    end else begin
      rad = eff_radius();
      x = $signed(req.centre_col);
      y = $signed(req.centre_row);
      left = (x - rad > 0) ? x - rad : 0;
      top = (y - rad > 0) ? y - rad : 0;
      right = (x + rad < bw) ? x + rad : bw;
      bottom = (y + rad < bh) ? y + rad : bh;
      w = right - left;
      h = bottom - top;
      rr = rad * rad;
      // The clipped width is rounded down to an even count.
      if (w > 0) w = w & ~1;
      if (w > 0 && h > 0) begin
        for (row = top; row < top + h; row++) begin
          dy = row - y;
          for (col = left; col < left + w; col++) begin
            dx = col - x;
            idx = row * CANVAS_W + col;
            mask = (dx * dx + dy * dy < rr) ? cbs_pkg::ALPHA_FULL : '0;
            alpha = (canvas[idx][cbs_pkg::PIXEL_W-1 -: cbs_pkg::CHAN_W] > mask) ?
                    canvas[idx][cbs_pkg::PIXEL_W-1 -: cbs_pkg::CHAN_W] : mask;
            // Any pixel with alpha takes the current ink, inside the circle or not.
            if (alpha != 0) canvas[idx] = {alpha, blue_reg, green_reg, red_reg};
          end
        end
        want.region_left = left[cbs_pkg::REGION_POS_W-1:0];
        want.region_top  = top[cbs_pkg::REGION_POS_W-1:0];
        want.region_cols = w[cbs_pkg::REGION_SIZE_W-1:0];
        want.region_rows = h[cbs_pkg::REGION_SIZE_W-1:0];
      end
    end
    pending_replies.push_back(want);
  endfunction

  task flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MAX) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task compare_field(string label, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s is %0d, expected %0d", label, got, want));
  endtask

  task check_reply(brush_reply_t got);
    brush_reply_t want;
    if (pending_replies.size() == 0) begin
      flag_mismatch("result beat with no result outstanding");
      return;
    end
    want = pending_replies.pop_front();
    compare_field("region_left", got.region_left, want.region_left);
    compare_field("region_top",  got.region_top,  want.region_top);
    compare_field("region_cols", got.region_cols, want.region_cols);
    compare_field("region_rows", got.region_rows, want.region_rows);
    compare_field("pixel_red",   got.pixel_red,   want.pixel_red);
    compare_field("pixel_green", got.pixel_green, want.pixel_green);
    compare_field("pixel_blue",  got.pixel_blue,  want.pixel_blue);
    compare_field("pixel_alpha", got.pixel_alpha, want.pixel_alpha);
  endtask
endclass

module tb_top;
  localparam int     HALF_PERIOD   = 6;
  localparam longint LIMIT_NS      = 80_000_000;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     RANDOM_PHASES = 4;
  localparam int     PHASE_ITEMS   = 30;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [cbs_pkg::REG_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
  localparam logic [cbs_pkg::REG_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

  logic                            clk;
  logic                            rst;
  logic                            write_en;
  logic [cbs_pkg::REG_INDEX_W-1:0] reg_index;
  logic [cbs_pkg::CFG_DATA_W-1:0]  write_data;

  cbs_item_if   item_ch ();
  cbs_result_if result_ch ();

  canvas_model  model;
  brush_reply_t seen;
  int           aim_col, aim_row;
  bit           tx_eager;
  int           tx_run_left;

  circular_brush_stamp_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .item       (item_ch),
    .result     (result_ch)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Hard limit on the whole run.
  initial begin
    #(LIMIT_NS);
    $display("tb_top: errors");
    $finish;
  end

  // Check every result beat at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen = {result_ch.region_left, result_ch.region_top, result_ch.region_cols,
              result_ch.region_rows, result_ch.pixel_red, result_ch.pixel_green,
              result_ch.pixel_blue, result_ch.pixel_alpha};
      model.check_reply(seen);
    end
  end

  // Result side: ready is held low at random between beats, with runs of no stalls at all.
  initial begin : result_sink
    int stall;
    int run_left;
    bit eager;
    run_left = 0;
    eager = 1'b0;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (run_left == 0) begin
        eager = ($urandom_range(0, 2) == 0);
        run_left = $urandom_range(4, 20);
      end
      run_left--;
      stall = eager ? 0 : $urandom_range(0, 11);
      repeat (stall) @(negedge clk) result_ch.ready <= 1'b0;
      @(negedge clk) result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  // One item beat, after a random gap; the model takes it once accepted.
  task automatic send_request(brush_req_t req);
    int gap;
    if (tx_run_left == 0) begin
      tx_eager = ($urandom_range(0, 2) == 0);
      tx_run_left = $urandom_range(4, 20);
    end
    tx_run_left--;
    gap = tx_eager ? 0 : $urandom_range(0, 11);
    repeat (gap) @(negedge clk) item_ch.valid <= 1'b0;
    @(negedge clk);
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= req.opcode;
    item_ch.centre_col <= req.centre_col;
    item_ch.centre_row <= req.centre_row;
    item_ch.read_col   <= req.read_col;
    item_ch.read_row   <= req.read_row;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    model.accept_request(req);
  endtask

  task automatic stamp_at(int x, int y);
    brush_req_t req;
    req.opcode     = cbs_pkg::OP_STAMP;
    req.centre_col = x[cbs_pkg::CENTRE_W-1:0];
    req.centre_row = y[cbs_pkg::CENTRE_W-1:0];
    req.read_col   = cbs_pkg::READ_POS_W'($urandom_range(0, 511));
    req.read_row   = cbs_pkg::READ_POS_W'($urandom_range(0, 511));
    aim_col = x;
    aim_row = y;
    send_request(req);
  endtask

  task automatic read_at(int c, int r);
    brush_req_t req;
    req.opcode     = cbs_pkg::OP_READ;
    req.centre_col = cbs_pkg::CENTRE_W'($urandom_range(0, 4095));
    req.centre_row = cbs_pkg::CENTRE_W'($urandom_range(0, 4095));
    req.read_col   = c[cbs_pkg::READ_POS_W-1:0];
    req.read_row   = r[cbs_pkg::READ_POS_W-1:0];
    send_request(req);
  endtask

  // Lower valid and wait until every result is in and the unit has settled.
  task automatic drain();
    @(negedge clk) item_ch.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [cbs_pkg::REG_INDEX_W-1:0] idx, int data);
    @(negedge clk);
    write_en   <= 1'b1;
    reg_index  <= idx;
    write_data <= data[cbs_pkg::CFG_DATA_W-1:0];
    @(negedge clk) write_en <= 1'b0;
    model.set_register(idx, data[cbs_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic set_brush(int w, int h, int r, int red, int green, int blue);
    write_reg(cbs_pkg::REG_BOARD_WIDTH, w);
    write_reg(cbs_pkg::REG_BOARD_HEIGHT, h);
    write_reg(cbs_pkg::REG_BRUSH_RADIUS, r);
    write_reg(cbs_pkg::REG_INK_RED, red);
    write_reg(cbs_pkg::REG_INK_GREEN, green);
    write_reg(cbs_pkg::REG_INK_BLUE, blue);
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin : stimulus
    int phase, n, w, h, r, bw, bh, rad, x, y, c, rw;
    model = new;
    tx_eager = 1'b0;
    tx_run_left = 0;
    aim_col = 0;
    aim_row = 0;
    rst = 1'b1;
    write_en = 1'b0;
    reg_index = '0;
    write_data = '0;
    item_ch.valid = 1'b0;
    item_ch.opcode = cbs_pkg::OP_STAMP;
    item_ch.centre_col = '0;
    item_ch.centre_row = '0;
    item_ch.read_col = '0;
    item_ch.read_row = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset settings: cleared store, circle inside the board, clipping at
    // every edge, odd widths and centres far off the board.
    read_at(0, 0);
    read_at(511, 511);
    stamp_at(100, 100);
    read_at(100, 100);
    read_at(93, 100);
    read_at(92, 100);
    stamp_at(0, 0);
    stamp_at(511, 511);
    stamp_at(-2048, -2048);
    stamp_at(2047, 2047);
    stamp_at(-7, 40);

    // Large brush over an earlier circle; the old pixels take the new ink.
    drain();
    set_brush(120, 120, 32, 8'h12, 8'h34, 8'h56);
    write_reg(REG_SPARE_LOW, 10'h3FF);
    write_reg(REG_SPARE_HIGH, 10'h2AA);
    stamp_at(105, 100);
    read_at(92, 100);
    read_at(511, 511);

    // Oversized registers act as the limits; pixels outlive a resize.
    drain();
    set_brush(1023, 1023, 63, 8'h00, 8'h00, 8'h00);
    read_at(511, 511);
    stamp_at(511, 0);
    read_at(500, 5);

    // Short board: reads below it return nothing, stamps clip at the bottom.
    drain();
    set_brush(512, 40, 5, 8'hFF, 8'h80, 8'h01);
    read_at(100, 100);
    stamp_at(20, 38);

    // Zero width, a one-pixel width and a zero radius all give empty stamps.
    drain();
    write_reg(cbs_pkg::REG_BOARD_WIDTH, 0);
    stamp_at(20, 20);
    drain();
    write_reg(cbs_pkg::REG_BOARD_WIDTH, 1);
    stamp_at(0, 10);
    drain();
    write_reg(cbs_pkg::REG_BOARD_WIDTH, 512);
    write_reg(cbs_pkg::REG_BRUSH_RADIUS, 0);
    stamp_at(50, 10);

    // Random phases, each under its own settings.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case ($urandom_range(0, 9))
        0: w = $urandom_range(513, 1023);
        1: w = $urandom_range(1, 16);
        default: w = $urandom_range(17, 512);
      endcase
      case ($urandom_range(0, 9))
        0: h = $urandom_range(513, 1023);
        1: h = $urandom_range(1, 16);
        default: h = $urandom_range(17, 512);
      endcase
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12);
      set_brush(w, h, r, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
      bw = model.eff_width();
      bh = model.eff_height();
      rad = model.eff_radius();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Now and then hold off until the unit has nothing outstanding.
        if ($urandom_range(0, 19) == 0) drain();
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 7) == 0) begin
            x = int'($urandom_range(0, 4095)) - 2048;
            y = int'($urandom_range(0, 4095)) - 2048;
          end else begin
            x = int'($urandom_range(0, bw + 2 * rad + 2)) - rad - 1;
            y = int'($urandom_range(0, bh + 2 * rad + 2)) - rad - 1;
          end
          stamp_at(x, y);
        end else begin
          if ($urandom_range(0, 9) < 6) begin
            c = aim_col + int'($urandom_range(0, 2 * rad)) - rad;
            rw = aim_row + int'($urandom_range(0, 2 * rad)) - rad;
            c = (c < 0) ? 0 : ((c > 511) ? 511 : c);
            rw = (rw < 0) ? 0 : ((rw > 511) ? 511 : rw);
          end else begin
            c = $urandom_range(0, 511);
            rw = $urandom_range(0, 511);
          end
          read_at(c, rw);
        end
      end
    end

    drain();
    if (model.mismatch_count == 0 && model.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/cbs_pkg.sv
hdl/cbs_channels.sv
hdl/cbs_ram.sv
hdl/circular_brush_stamp_unit.sv
tb/tb_top.sv
